@@ design/fbrf_pkg.sv @@
// Shared types and constants of the frame buffer with clipped pixel and rectangle fill.
`default_nettype none

package fbrf_pkg;

	localparam int unsigned MAX_WIDTH  = 128;
	localparam int unsigned MAX_HEIGHT = 128;
	localparam int unsigned COLOR_BITS = 32;

	localparam int unsigned COORD_BITS = 8;
	localparam int unsigned DIM_BITS   = 8;
	localparam int unsigned PORT_COLOR = 32;
	localparam int unsigned CFG_BITS   = 8;

	localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RESET  = 8'd128;
	localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RESET = 8'd128;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_FILL  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_FILL = 3'b100
	} state_t;

endpackage

`default_nettype wire

@@ design/fbrf_if.sv @@
// Handshake channels of the frame buffer: commands, responses and register writes.
`default_nettype none

interface fbrf_cmd_if;
	logic                               valid;
	logic                               ready;
	fbrf_pkg::kind_t                    kind;
	logic [fbrf_pkg::COORD_BITS-1:0]    x;
	logic [fbrf_pkg::COORD_BITS-1:0]    y;
	logic [fbrf_pkg::DIM_BITS-1:0]      rect_width;
	logic [fbrf_pkg::DIM_BITS-1:0]      rect_height;
	logic [fbrf_pkg::PORT_COLOR-1:0]    color;

	modport source (output valid, kind, x, y, rect_width, rect_height, color, input ready);
	modport sink   (input valid, kind, x, y, rect_width, rect_height, color, output ready);
endinterface

interface fbrf_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [fbrf_pkg::PORT_COLOR-1:0]    read_color;
	logic                               range_error;

	modport source (output valid, read_color, range_error, input ready);
	modport sink   (input valid, read_color, range_error, output ready);
endinterface

interface fbrf_cfg_if;
	logic                               valid;
	logic                               ready;
	fbrf_pkg::reg_index_t               index;
	logic [fbrf_pkg::CFG_BITS-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/fbrf_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
`default_nettype none

module fbrf_ram #(
	parameter int unsigned WIDTH = fbrf_pkg::COLOR_BITS,
	parameter int unsigned DEPTH = fbrf_pkg::MAX_WIDTH * fbrf_pkg::MAX_HEIGHT,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

@@ design/frame_buffer_rect_fill.sv @@
// Frame buffer with clipped pixel write, pixel read and rectangle fill.
//
// Colour words sit row-major in one single-port RAM of MAX_WIDTH*MAX_HEIGHT
// entries, the row stride being the frame width clipped to MAX_WIDTH. Every
// command gives exactly one response. A pixel write, an out-of-frame read, an
// empty fill or the unused command code is answered on acceptance; an in-frame
// read goes through ST_READ, as the RAM read data is registered. A fill walks the
// rectangle row by row, one RAM write per in-frame pixel; pixels outside the
// frame are skipped in place. One command is in progress at a time, and the
// next is taken once the response register is free or being emptied. The store
// has no reset and needs no clearing pass: a pixel must be written before it is
// read. Register writes are taken at any time but belong only to an idle block.
`default_nettype none

module frame_buffer_rect_fill #(
	parameter int unsigned MAX_WIDTH  = fbrf_pkg::MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = fbrf_pkg::MAX_HEIGHT,
	parameter int unsigned COLOR_BITS = fbrf_pkg::COLOR_BITS
) (
	input wire logic   clk,
	input wire logic   arst_n,
	fbrf_cmd_if.sink   cmd,
	fbrf_rsp_if.source rsp,
	fbrf_cfg_if.sink   cfg
);

	localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CB    = fbrf_pkg::COORD_BITS;
	localparam int unsigned DB    = fbrf_pkg::DIM_BITS;
	localparam int unsigned PC    = fbrf_pkg::PORT_COLOR;

	fbrf_pkg::state_t state_q;

	logic [fbrf_pkg::CFG_BITS-1:0] frame_width_q;
	logic [fbrf_pkg::CFG_BITS-1:0] frame_height_q;
	logic [CB-1:0]                 eff_w;
	logic [CB-1:0]                 eff_h;

	logic [CB-1:0]         x_q;
	logic [CB-1:0]         y_q;
	logic [DB-1:0]         rw_q;
	logic [DB-1:0]         rh_q;
	logic [COLOR_BITS-1:0] color_q;
	logic [DB-1:0]         col_q;
	logic [DB-1:0]         row_q;

	logic          rsp_valid_q;
	logic [PC-1:0] read_color_q;
	logic          range_error_q;

	logic          out_free;
	logic          accept;
	logic          load_out;
	logic [PC-1:0] load_color;
	logic          load_error;
	logic          col_last;
	logic          row_last;

	logic [CB:0]           px;
	logic [CB:0]           py;
	logic                  in_frame;
	logic [2*CB-1:0]       row_base;
	logic [2*CB:0]         addr_sum;
	logic                  ram_we;
	logic [COLOR_BITS-1:0] ram_wdata;
	logic [COLOR_BITS-1:0] ram_rdata;

	// Saturate the configured frame to the store's dimensions
	always_comb begin
		eff_w = (32'(frame_width_q) > MAX_WIDTH) ? CB'(MAX_WIDTH) : frame_width_q;
		eff_h = (32'(frame_height_q) > MAX_HEIGHT) ? CB'(MAX_HEIGHT) : frame_height_q;
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= fbrf_pkg::FRAME_WIDTH_RESET;
			frame_height_q <= fbrf_pkg::FRAME_HEIGHT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				fbrf_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg.data;
				fbrf_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign cmd.ready = (state_q == fbrf_pkg::ST_IDLE) && out_free;
	assign accept    = cmd.valid && cmd.ready;

	assign col_last = (col_q == rw_q - DB'(1));
	assign row_last = (row_q == rh_q - DB'(1));

	// Pixel under the single RAM port: the command itself when idle, the scan otherwise
	always_comb begin
		if (state_q == fbrf_pkg::ST_FILL) begin
			px = {1'b0, x_q} + {1'b0, col_q};
			py = {1'b0, y_q} + {1'b0, row_q};
		end else begin
			px = {1'b0, cmd.x};
			py = {1'b0, cmd.y};
		end
		in_frame = (px < {1'b0, eff_w}) && (py < {1'b0, eff_h});
		row_base = (2*CB)'(py[CB-1:0]) * (2*CB)'(eff_w);
		addr_sum = {1'b0, row_base} + {{(CB+1){1'b0}}, px[CB-1:0]};
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = color_q;
		if (state_q == fbrf_pkg::ST_FILL) begin
			ram_we = in_frame;
		end else if (accept && cmd.kind == fbrf_pkg::KIND_WRITE) begin
			ram_we    = in_frame;
			ram_wdata = COLOR_BITS'(cmd.color);
		end
	end

	fbrf_ram #(
		.WIDTH (COLOR_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (AW'(addr_sum)),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Response to load into the output register this cycle
	always_comb begin
		load_out   = 1'b0;
		load_color = '0;
		load_error = 1'b0;
		case (state_q)
			fbrf_pkg::ST_IDLE: begin
				if (accept) begin
					case (cmd.kind)
						fbrf_pkg::KIND_READ: begin
							load_out   = !in_frame;
							load_error = !in_frame;
						end
						fbrf_pkg::KIND_FILL: begin
							load_out = (cmd.rect_width == '0) || (cmd.rect_height == '0);
						end
						default: load_out = 1'b1;
					endcase
				end
			end
			fbrf_pkg::ST_READ: begin
				load_out   = 1'b1;
				load_color = PC'(ram_rdata);
			end
			fbrf_pkg::ST_FILL: begin
				load_out = col_last && row_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbrf_pkg::ST_IDLE;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			case (state_q)
				fbrf_pkg::ST_IDLE: begin
					if (accept && cmd.kind == fbrf_pkg::KIND_READ && in_frame) begin
						state_q <= fbrf_pkg::ST_READ;
					end else if (accept && cmd.kind == fbrf_pkg::KIND_FILL &&
							cmd.rect_width != '0 && cmd.rect_height != '0) begin
						state_q <= fbrf_pkg::ST_FILL;
					end
				end
				fbrf_pkg::ST_READ: state_q <= fbrf_pkg::ST_IDLE;
				fbrf_pkg::ST_FILL: begin
					// advance along the row, wrap to the next, leave counters at zero
					if (col_last) begin
						col_q <= '0;
						if (row_last) begin
							row_q   <= '0;
							state_q <= fbrf_pkg::ST_IDLE;
						end else begin
							row_q <= row_q + DB'(1);
						end
					end else begin
						col_q <= col_q + DB'(1);
					end
				end
				default: state_q <= fbrf_pkg::ST_IDLE;
			endcase
		end
	end

	// Hold the fill command for the scan
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q     <= cmd.x;
			y_q     <= cmd.y;
			rw_q    <= cmd.rect_width;
			rh_q    <= cmd.rect_height;
			color_q <= COLOR_BITS'(cmd.color);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			read_color_q  <= load_color;
			range_error_q <= load_error;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.read_color  = read_color_q;
	assign rsp.range_error = range_error_q;

	a_load_free : assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!rsp_valid_q || rsp.ready))
		else $error("response loaded over an untaken transfer");

	a_read_answers : assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fbrf_pkg::ST_READ |=> rsp_valid_q)
		else $error("read did not produce a response");

	a_scan_bounds : assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fbrf_pkg::ST_FILL |-> (col_q < rw_q && row_q < rh_q))
		else $error("fill scan left the rectangle");

	a_scan_rest : assert property (@(posedge clk) disable iff (!arst_n)
		state_q != fbrf_pkg::ST_FILL |-> (col_q == '0 && row_q == '0))
		else $error("fill counters not at zero outside a fill");

	a_write_clipped : assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (px < {1'b0, eff_w} && py < {1'b0, eff_h} && addr_sum < (2*CB+1)'(DEPTH)))
		else $error("store written outside the frame");

endmodule

`default_nettype wire
